// File: rtl/cle_pkg.sv
// Shared types and constants for the console line editor.
// Holds character codes, command codes and the queue entry type; no dependencies.
package cle_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_EOF  = 8'h04;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_DUMP = 8'h10;
    localparam logic [7:0] CH_KILL = 8'h15;
    localparam logic [7:0] CH_DEL  = 8'h7F;

    localparam logic [2:0] OP_IGNORE = 3'd0;
    localparam logic [2:0] OP_DUMP   = 3'd1;
    localparam logic [2:0] OP_KILL   = 3'd2;
    localparam logic [2:0] OP_ERASE  = 3'd3;
    localparam logic [2:0] OP_STORE  = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic       first;
    } cle_cmd_t;

endpackage

// File: rtl/console_line_editor_core.sv
// Canonical console line editor: takes one received character or one reader
// request per transaction and returns one result per transaction, sustaining
// one transaction per cycle while m_ready stays high. An accepted transaction
// enters a two-entry queue and passes from the queue register to the result
// register of the back end, which drives the m_ side; the back end updates the
// indices as it takes each command and keeps the byte at the read index
// prefetched from the line store, so a read can follow a write in the next cycle.
// The queue frees the input side while a result waits: up to two more
// transactions are accepted into the queue before s_ready drops.
// No clearing pass after reset; the line store is undefined until written.
module console_line_editor_core #(
    parameter int BUFFER_DEPTH = cle_pkg::BUFFER_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_rx_char,
    input  logic       s_first_of_read,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_echo_valid,
    output logic [7:0] m_echo_char,
    output logic [7:0] m_erase_count,
    output logic       m_line_ready,
    output logic       m_dump_request,
    output logic       m_dropped,
    output logic       m_read_valid,
    output logic [7:0] m_read_byte,
    output logic       m_read_end_line,
    output logic       m_read_eof,
    output logic       m_read_empty
);
    import cle_pkg::*;

    cle_cmd_t front_cmd;
    cle_cmd_t back_cmd;
    logic     front_valid, front_ready;
    logic     back_valid, back_ready;

    cle_front u_front (
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .func          (s_func),
        .rx_char       (s_rx_char),
        .first_of_read (s_first_of_read),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    cle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    cle_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (back_valid),
        .cmd_ready       (back_ready),
        .cmd             (back_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_echo_valid    (m_echo_valid),
        .m_echo_char     (m_echo_char),
        .m_erase_count   (m_erase_count),
        .m_line_ready    (m_line_ready),
        .m_dump_request  (m_dump_request),
        .m_dropped       (m_dropped),
        .m_read_valid    (m_read_valid),
        .m_read_byte     (m_read_byte),
        .m_read_end_line (m_read_end_line),
        .m_read_eof      (m_read_eof),
        .m_read_empty    (m_read_empty)
    );

endmodule

// File: rtl/cle_front.sv
// Front end: classifies each received transaction into an editor command.
// Depends on cle_pkg.
module cle_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [7:0]         rx_char,
    input  logic               first_of_read,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output cle_pkg::cle_cmd_t  cmd
);
    import cle_pkg::*;

    assign cmd_valid = in_valid;
    assign in_ready  = cmd_ready;

    always_comb begin
        cmd.first = first_of_read;
        cmd.ch    = rx_char;
        priority if (func) begin
            cmd.op = OP_READ;
        end else if (rx_char == CH_DUMP) begin
            cmd.op = OP_DUMP;
        end else if (rx_char == CH_KILL) begin
            cmd.op = OP_KILL;
        end else if (rx_char == CH_BS || rx_char == CH_DEL) begin
            cmd.op = OP_ERASE;
        end else if (rx_char == CH_NUL) begin
            cmd.op = OP_IGNORE;
        end else begin
            cmd.op = OP_STORE;
            if (rx_char == CH_CR) begin
                cmd.ch = CH_NL;
            end
        end
    end

endmodule

// File: rtl/cle_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on cle_pkg.
module cle_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cle_pkg::cle_cmd_t  in_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output cle_pkg::cle_cmd_t  out_cmd
);
    import cle_pkg::*;

    cle_cmd_t   entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: rtl/cle_back.sv
// Back end: ring buffer, read/commit/edit indices and the result register.
// Depends on cle_pkg; the line store is a memory with a prefetched head byte.
module cle_back #(
    parameter int BUFFER_DEPTH = cle_pkg::BUFFER_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cle_pkg::cle_cmd_t  cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_echo_valid,
    output logic [7:0]         m_echo_char,
    output logic [7:0]         m_erase_count,
    output logic               m_line_ready,
    output logic               m_dump_request,
    output logic               m_dropped,
    output logic               m_read_valid,
    output logic [7:0]         m_read_byte,
    output logic               m_read_end_line,
    output logic               m_read_eof,
    output logic               m_read_empty
);
    import cle_pkg::*;

    localparam int IW = $clog2(2 * BUFFER_DEPTH);
    localparam int SW = $clog2(BUFFER_DEPTH);
    localparam logic [IW-1:0] DEPTH_I   = IW'(BUFFER_DEPTH);
    localparam logic [IW-1:0] DEPTH_M1  = IW'(BUFFER_DEPTH - 1);
    localparam logic [IW-1:0] IDX_MAX   = IW'(2 * BUFFER_DEPTH - 1);
    localparam logic [IW-1:0] IDX_MOD_I = IW'(2 * BUFFER_DEPTH);

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
        return (a == IDX_MAX) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
        return (a == '0) ? IDX_MAX : a - 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        return (a >= b) ? a - b : a - b + IDX_MOD_I;
    endfunction

    function automatic logic [SW-1:0] idx_slot(input logic [IW-1:0] a);
        logic [IW-1:0] s;
        s = (a >= DEPTH_I) ? a - DEPTH_I : a;
        return s[SW-1:0];
    endfunction

    logic [7:0]    line_store [BUFFER_DEPTH];
    logic [7:0]    head_reg;
    logic [IW-1:0] read_reg, read_next;
    logic [IW-1:0] commit_reg, commit_next;
    logic [IW-1:0] edit_reg, edit_next;
    logic          out_valid_reg;

    logic          pop;
    logic          we;
    logic [SW-1:0] wr_slot;
    logic [SW-1:0] read_slot_next;
    logic [IW-1:0] fill;
    logic [IW-1:0] uncommitted;

    logic          echo_valid_reg, echo_valid_next;
    logic [7:0]    echo_char_reg, echo_char_next;
    logic [7:0]    erase_reg, erase_next;
    logic          line_ready_reg, line_ready_next;
    logic          dump_reg, dump_next;
    logic          dropped_reg, dropped_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [7:0]    rd_byte_reg, rd_byte_next;
    logic          rd_nl_reg, rd_nl_next;
    logic          rd_eof_reg, rd_eof_next;
    logic          rd_empty_reg, rd_empty_next;

    assign cmd_ready   = !out_valid_reg || m_ready;
    assign pop         = cmd_valid && cmd_ready;
    assign fill        = idx_diff(edit_reg, read_reg);
    assign uncommitted = idx_diff(edit_reg, commit_reg);
    assign wr_slot     = idx_slot(edit_reg);

    always_comb begin
        read_next       = read_reg;
        commit_next     = commit_reg;
        edit_next       = edit_reg;
        we              = 1'b0;
        echo_valid_next = 1'b0;
        echo_char_next  = 8'd0;
        erase_next      = 8'd0;
        line_ready_next = 1'b0;
        dump_next       = 1'b0;
        dropped_next    = 1'b0;
        rd_valid_next   = 1'b0;
        rd_byte_next    = 8'd0;
        rd_nl_next      = 1'b0;
        rd_eof_next     = 1'b0;
        rd_empty_next   = 1'b0;
        if (pop) begin
            unique case (cmd.op)
                OP_DUMP: begin
                    dump_next = 1'b1;
                end
                OP_KILL: begin
                    erase_next = 8'(uncommitted);
                    edit_next  = commit_reg;
                end
                OP_ERASE: begin
                    if (edit_reg != commit_reg) begin
                        edit_next  = idx_dec(edit_reg);
                        erase_next = 8'd1;
                    end
                end
                OP_STORE: begin
                    if (fill != DEPTH_I) begin
                        we              = 1'b1;
                        echo_valid_next = 1'b1;
                        echo_char_next  = cmd.ch;
                        edit_next       = idx_inc(edit_reg);
                        if (cmd.ch == CH_NL || cmd.ch == CH_EOF || fill == DEPTH_M1) begin
                            commit_next     = edit_next;
                            line_ready_next = 1'b1;
                        end
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
                OP_READ: begin
                    if (read_reg == commit_reg) begin
                        rd_empty_next = 1'b1;
                    end else if (head_reg == CH_EOF) begin
                        rd_eof_next = 1'b1;
                        if (cmd.first) begin
                            read_next = idx_inc(read_reg);
                        end
                    end else begin
                        read_next     = idx_inc(read_reg);
                        rd_valid_next = 1'b1;
                        rd_byte_next  = head_reg;
                        rd_nl_next    = (head_reg == CH_NL);
                    end
                end
                default: begin
                end
            endcase
        end
        read_slot_next = idx_slot(read_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_reg      <= '0;
            commit_reg    <= '0;
            edit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            read_reg   <= read_next;
            commit_reg <= commit_next;
            edit_reg   <= edit_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            line_store[wr_slot] <= cmd.ch;
        end
        if (we && wr_slot == read_slot_next) begin
            head_reg <= cmd.ch;
        end else begin
            head_reg <= line_store[read_slot_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            echo_valid_reg <= echo_valid_next;
            echo_char_reg  <= echo_char_next;
            erase_reg      <= erase_next;
            line_ready_reg <= line_ready_next;
            dump_reg       <= dump_next;
            dropped_reg    <= dropped_next;
            rd_valid_reg   <= rd_valid_next;
            rd_byte_reg    <= rd_byte_next;
            rd_nl_reg      <= rd_nl_next;
            rd_eof_reg     <= rd_eof_next;
            rd_empty_reg   <= rd_empty_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_echo_valid    = echo_valid_reg;
    assign m_echo_char     = echo_char_reg;
    assign m_erase_count   = erase_reg;
    assign m_line_ready    = line_ready_reg;
    assign m_dump_request  = dump_reg;
    assign m_dropped       = dropped_reg;
    assign m_read_valid    = rd_valid_reg;
    assign m_read_byte     = rd_byte_reg;
    assign m_read_end_line = rd_nl_reg;
    assign m_read_eof      = rd_eof_reg;
    assign m_read_empty    = rd_empty_reg;

endmodule

// File: rtl/cle_checker.sv
// Port-level checks for console_line_editor_core, attached by bind.
// Depends on cle_pkg for character codes.
module cle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_echo_valid,
    input logic [7:0] m_echo_char,
    input logic [7:0] m_erase_count,
    input logic       m_line_ready,
    input logic       m_dropped,
    input logic       m_read_valid,
    input logic [7:0] m_read_byte,
    input logic       m_read_end_line,
    input logic       m_read_eof,
    input logic       m_read_empty
);
    import cle_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_byte) && $stable(m_echo_char))
        else $error("result changed while stalled");

    a_commit_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_ready |-> m_echo_valid && !m_dropped && m_erase_count == 8'd0)
        else $error("commit without stored character");

    a_read_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_valid |-> !m_read_empty && !m_read_eof && !m_echo_valid)
        else $error("delivered byte with conflicting status");

    a_end_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_end_line |-> m_read_valid && m_read_byte == CH_NL)
        else $error("end of line flag without newline byte");

endmodule

bind console_line_editor_core cle_checker u_cle_checker (.*);
